>>> rtl/ffl_pkg.sv
package ffl_pkg;

   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;

   // wide enough for any canvas edge up to 4096
   localparam int COORD_W     = 13;
   localparam int CFG_W       = 9;
   localparam int COUNT_W     = 17;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [2:0] CMD_FILL    = 3'd0;
   localparam logic [2:0] CMD_STIPPLE = 3'd1;
   localparam logic [2:0] CMD_PIXEL   = 3'd2;
   localparam logic [2:0] CMD_HLINE   = 3'd3;
   localparam logic [2:0] CMD_VLINE   = 3'd4;
   localparam logic [2:0] CMD_OUTLINE = 3'd5;
   localparam logic [2:0] CMD_READ    = 3'd6;

   localparam logic REG_CANVAS_WIDTH  = 1'b0;
   localparam logic REG_CANVAS_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      SPAN_NONE,
      SPAN_WRITE,
      SPAN_READ
   } span_op_type;

   // one clipped rectangle of work, end coordinates exclusive
   typedef struct packed {
      span_op_type          op;
      logic                 stip;
      logic                 last;
      logic [7:0]           color;
      logic [COORD_W-1:0]   x0;
      logic [COORD_W-1:0]   x1;
      logic [COORD_W-1:0]   y0;
      logic [COORD_W-1:0]   y1;
   } span_type;

endpackage

>>> rtl/ffl_front.sv
module ffl_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_cmd,
   input  logic signed [15:0]            req_pos_x,
   input  logic signed [15:0]            req_pos_y,
   input  logic signed [15:0]            req_extent_a,
   input  logic signed [15:0]            req_extent_b,
   input  logic [7:0]                    req_color,
   input  logic [ffl_pkg::COORD_W-1:0]   eff_w,
   input  logic [ffl_pkg::COORD_W-1:0]   eff_h,
   input  logic                          clr_done,
   input  logic                          q_full,
   output logic                          q_push,
   output ffl_pkg::span_type             q_span
);

   typedef enum logic {FE_IDLE, FE_GEN} fe_state_type;

   typedef struct packed {
      logic [ffl_pkg::COORD_W-1:0] lo;
      logic [ffl_pkg::COORD_W-1:0] hi;
      logic                        ok;
   } range_type;

   fe_state_type         state_ff, state_in;
   logic [1:0]           step_ff, step_in;
   logic [2:0]           cmd_ff, cmd_in;
   logic signed [15:0]   px_ff, px_in, py_ff, py_in, ea_ff, ea_in, eb_ff, eb_in;
   logic [7:0]           color_ff, color_in;

   logic signed [17:0]   px_s, py_s, ea_s, eb_s;
   logic signed [17:0]   xa, xb, ya, yb;
   logic                 sw_x, sw_y, stip, last;
   ffl_pkg::span_op_type op;
   range_type            rx, ry;

   // order the end points if asked, then clip to [0, lim)
   function automatic range_type clip(input logic signed [17:0] a,
                                      input logic signed [17:0] b,
                                      input logic swap,
                                      input logic [ffl_pkg::COORD_W-1:0] lim);
      logic signed [17:0] lo_s;
      logic signed [17:0] hi_s;
      logic signed [17:0] lim_s;
      range_type          r;
      lo_s  = (swap && (b < a)) ? b : a;
      hi_s  = (swap && (b < a)) ? a : b;
      lim_s = $signed({{(18 - ffl_pkg::COORD_W){1'b0}}, lim});
      if (lo_s < 18'sd0) begin
         lo_s = 18'sd0;
      end
      if (hi_s > lim_s) begin
         hi_s = lim_s;
      end
      r.ok = lo_s < hi_s;
      r.lo = lo_s[ffl_pkg::COORD_W-1:0];
      r.hi = hi_s[ffl_pkg::COORD_W-1:0];
      return r;
   endfunction

   assign px_s = {{2{px_ff[15]}}, px_ff};
   assign py_s = {{2{py_ff[15]}}, py_ff};
   assign ea_s = {{2{ea_ff[15]}}, ea_ff};
   assign eb_s = {{2{eb_ff[15]}}, eb_ff};

   always_comb begin
      xa   = px_s;
      xb   = px_s + 18'sd1;
      ya   = py_s;
      yb   = py_s + 18'sd1;
      sw_x = 1'b0;
      sw_y = 1'b0;
      stip = 1'b0;
      last = 1'b1;
      op   = ffl_pkg::SPAN_WRITE;
      unique case (cmd_ff) inside
         ffl_pkg::CMD_FILL, ffl_pkg::CMD_STIPPLE: begin
            xb   = px_s + ea_s;
            yb   = py_s + eb_s;
            stip = (cmd_ff == ffl_pkg::CMD_STIPPLE);
         end
         ffl_pkg::CMD_PIXEL: begin
            op = ffl_pkg::SPAN_WRITE;
         end
         ffl_pkg::CMD_HLINE: begin
            xb   = ea_s;
            sw_x = 1'b1;
         end
         ffl_pkg::CMD_VLINE: begin
            yb   = eb_s;
            sw_y = 1'b1;
         end
         ffl_pkg::CMD_OUTLINE: begin
            last = (step_ff == 2'd3);
            unique case (step_ff)
               2'd0: begin
                  xb   = ea_s + 18'sd1;
                  sw_x = 1'b1;
               end
               2'd1: begin
                  xb   = ea_s + 18'sd1;
                  sw_x = 1'b1;
                  ya   = eb_s;
                  yb   = eb_s + 18'sd1;
               end
               2'd2: begin
                  ya   = py_s + 18'sd1;
                  yb   = eb_s;
                  sw_y = 1'b1;
               end
               default: begin
                  xa   = ea_s;
                  xb   = ea_s + 18'sd1;
                  ya   = py_s + 18'sd1;
                  yb   = eb_s;
                  sw_y = 1'b1;
               end
            endcase
         end
         ffl_pkg::CMD_READ: begin
            op = ffl_pkg::SPAN_READ;
         end
         default: begin
            op = ffl_pkg::SPAN_NONE;
         end
      endcase
   end

   assign rx = clip(xa, xb, sw_x, eff_w);
   assign ry = clip(ya, yb, sw_y, eff_h);

   always_comb begin
      q_span.op    = (rx.ok && ry.ok) ? op : ffl_pkg::SPAN_NONE;
      q_span.stip  = stip;
      q_span.last  = last;
      q_span.color = color_ff;
      q_span.x0    = rx.lo;
      q_span.x1    = rx.hi;
      q_span.y0    = ry.lo;
      q_span.y1    = ry.hi;
   end

   assign q_push    = (state_ff == FE_GEN) && !q_full;
   assign req_stall = (state_ff != FE_IDLE) || !clr_done;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd_in   = cmd_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      ea_in    = ea_ff;
      eb_in    = eb_ff;
      color_in = color_ff;
      unique case (state_ff)
         FE_IDLE: begin
            if (req_valid && !req_stall) begin
               state_in = FE_GEN;
               step_in  = 2'd0;
               cmd_in   = req_cmd;
               px_in    = req_pos_x;
               py_in    = req_pos_y;
               ea_in    = req_extent_a;
               eb_in    = req_extent_b;
               color_in = req_color;
            end
         end
         default: begin
            if (q_push) begin
               if (last) begin
                  state_in = FE_IDLE;
               end else begin
                  step_in = step_ff + 2'd1;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_IDLE;
         step_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
      cmd_ff   <= cmd_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      ea_ff    <= ea_in;
      eb_ff    <= eb_in;
      color_ff <= color_in;
   end

   a_accept_starts_gen: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == FE_GEN && step_ff == 2'd0))
      else $error("accepted word did not start span generation");

endmodule

>>> rtl/ffl_span_queue.sv
module ffl_span_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ffl_pkg::span_type  push_span,
   output logic               full,
   input  logic               pop,
   output logic               pop_valid,
   output ffl_pkg::span_type  pop_span
);

   localparam int PW = (ffl_pkg::QUEUE_DEPTH > 1) ? $clog2(ffl_pkg::QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(ffl_pkg::QUEUE_DEPTH + 1);

   ffl_pkg::span_type  entry_ff [ffl_pkg::QUEUE_DEPTH];
   logic [PW-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]      count_ff, count_in;

   assign full      = (count_ff == CW'(ffl_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_span  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(ffl_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(ffl_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_span;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("span popped from empty queue");

endmodule

>>> rtl/ffl_back.sv
module ffl_back #(
   parameter int MAX_WIDTH  = ffl_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = ffl_pkg::MAX_HEIGHT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ffl_pkg::COORD_W-1:0]   eff_w,
   output logic                          clr_done,
   input  logic                          q_valid,
   input  ffl_pkg::span_type             q_span,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_read_value,
   output logic [ffl_pkg::COUNT_W-1:0]   rsp_pixels_written
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CDW   = ffl_pkg::COORD_W;

   typedef enum logic [2:0] {
      BK_CLEAR, BK_IDLE, BK_BASE, BK_RUN, BK_RD, BK_RDW, BK_RDL, BK_DONE
   } bk_state_type;

   bk_state_type              state_ff, state_in;
   logic [AW-1:0]             clr_addr_ff, clr_addr_in;
   logic [CDW-1:0]            x_ff, x_in, y_ff, y_in;
   logic [CDW-1:0]            sx0_ff, sx0_in, sx1_ff, sx1_in, sy0_ff, sy0_in, sy1_ff, sy1_in;
   logic [7:0]                color_ff, color_in;
   logic                      stip_ff, stip_in, last_ff, last_in;
   logic [AW-1:0]             base_ff, base_in;
   logic [ffl_pkg::COUNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]                rv_ff, rv_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [7:0]                rsp_rv_ff, rsp_rv_in;
   logic [ffl_pkg::COUNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;

   logic [7:0]                pixel_mem_ff [DEPTH];
   logic [7:0]                rd_data_ff;

   logic [2*CDW-1:0]          prod;
   logic [AW-1:0]             pix_addr;
   logic                      we;
   logic [AW-1:0]             waddr;
   logic [7:0]                wdata;
   logic                      odd;
   logic                      row_end, col_end;
   logic                      out_free;

   assign prod     = y_ff * eff_w;
   assign pix_addr = base_ff + AW'(x_ff);
   assign odd      = x_ff[0] ^ sx0_ff[0] ^ y_ff[0] ^ sy0_ff[0];
   assign col_end  = (x_ff + CDW'(1)) == sx1_ff;
   assign row_end  = (y_ff + CDW'(1)) == sy1_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign clr_done = (state_ff != BK_CLEAR);
   assign q_pop    = (state_ff == BK_IDLE) && q_valid;

   assign we    = (state_ff == BK_CLEAR) || ((state_ff == BK_RUN) && (!stip_ff || !odd));
   assign waddr = (state_ff == BK_CLEAR) ? clr_addr_ff : pix_addr;
   assign wdata = (state_ff == BK_CLEAR) ? 8'd0 : color_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         pixel_mem_ff[waddr] <= wdata;
      end
      rd_data_ff <= pixel_mem_ff[pix_addr];
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      sx0_in       = sx0_ff;
      sx1_in       = sx1_ff;
      sy0_in       = sy0_ff;
      sy1_in       = sy1_ff;
      color_in     = color_ff;
      stip_in      = stip_ff;
      last_in      = last_ff;
      base_in      = base_ff;
      cnt_in       = cnt_ff;
      rv_in        = rv_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_rv_in    = rsp_rv_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      unique case (state_ff)
         BK_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (q_valid) begin
               x_in     = q_span.x0;
               y_in     = q_span.y0;
               sx0_in   = q_span.x0;
               sx1_in   = q_span.x1;
               sy0_in   = q_span.y0;
               sy1_in   = q_span.y1;
               color_in = q_span.color;
               stip_in  = q_span.stip;
               last_in  = q_span.last;
               unique case (q_span.op)
                  ffl_pkg::SPAN_WRITE: state_in = BK_BASE;
                  ffl_pkg::SPAN_READ:  state_in = BK_RD;
                  default:             state_in = q_span.last ? BK_DONE : BK_IDLE;
               endcase
            end
         end
         BK_BASE: begin
            base_in  = prod[AW-1:0];
            state_in = BK_RUN;
         end
         BK_RUN: begin
            if (!stip_ff || !odd) begin
               if (cnt_ff != ffl_pkg::COUNT_MAX) begin
                  cnt_in = cnt_ff + ffl_pkg::COUNT_W'(1);
               end
            end
            if (col_end) begin
               x_in    = sx0_ff;
               y_in    = y_ff + CDW'(1);
               base_in = base_ff + AW'(eff_w);
               if (row_end) begin
                  state_in = last_ff ? BK_DONE : BK_IDLE;
               end
            end else begin
               x_in = x_ff + CDW'(1);
            end
         end
         BK_RD: begin
            // single-row span: base is y0 * width, read issues next cycle
            base_in  = prod[AW-1:0];
            state_in = BK_RDW;
         end
         BK_RDW: begin
            state_in = BK_RDL;
         end
         BK_RDL: begin
            // read data for the address presented in BK_RDW, registered in rd_data_ff
            rv_in    = rd_data_ff;
            state_in = BK_DONE;
         end
         default: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_rv_in    = rv_ff;
               rsp_cnt_in   = cnt_ff;
               cnt_in       = '0;
               rv_in        = 8'd0;
               state_in     = BK_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_addr_ff  <= '0;
         cnt_ff       <= '0;
         rv_ff        <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         cnt_ff       <= cnt_in;
         rv_ff        <= rv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff       <= x_in;
      y_ff       <= y_in;
      sx0_ff     <= sx0_in;
      sx1_ff     <= sx1_in;
      sy0_ff     <= sy0_in;
      sy1_ff     <= sy1_in;
      color_ff   <= color_in;
      stip_ff    <= stip_in;
      last_ff    <= last_in;
      base_ff    <= base_in;
      rsp_rv_ff  <= rsp_rv_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_value     = rsp_rv_ff;
   assign rsp_pixels_written = rsp_cnt_ff;

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == BK_DONE))
      else $error("result word raised outside of completion");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      we |-> ({1'b0, waddr} < (AW + 1)'(DEPTH)))
      else $error("pixel write beyond store");

endmodule

>>> rtl/framebuffer_fill_line_engine_top.sv
// Reset: synchronous; after it the pixel store, MAX_WIDTH*MAX_HEIGHT pixels (65536 at
// defaults), is swept to zero one pixel per cycle, with req_stall held high meanwhile.
// Canvas registers reset to 256 and are writable during the sweep.
// Fill, stipple and lines walk their clipped area (stipple walks every pixel of the box),
// an outline draws its sides one after another, and a side clipped away is skipped.
// A span is walked at one pixel per cycle; a read fetches a single pixel.
module framebuffer_fill_line_engine_top #(
   parameter int MAX_WIDTH  = ffl_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = ffl_pkg::MAX_HEIGHT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_cmd,
   input  logic signed [15:0]            req_pos_x,
   input  logic signed [15:0]            req_pos_y,
   input  logic signed [15:0]            req_extent_a,
   input  logic signed [15:0]            req_extent_b,
   input  logic [7:0]                    req_color,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_read_value,
   output logic [ffl_pkg::COUNT_W-1:0]   rsp_pixels_written,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [2:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   localparam int CDW = ffl_pkg::COORD_W;
   localparam int CFW = ffl_pkg::CFG_W;

   logic [CFW-1:0]     cfg_w_ff, cfg_w_in, cfg_h_ff, cfg_h_in;
   logic [CDW-1:0]     eff_w, eff_h;
   logic               cfg_wr;
   logic               clr_done;
   logic               q_full, q_push, q_pop, q_valid;
   ffl_pkg::span_type  push_span, pop_span;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;

   always_comb begin
      cfg_w_in = cfg_w_ff;
      cfg_h_in = cfg_h_ff;
      if (cfg_wr) begin
         unique case (paddr[2])
            ffl_pkg::REG_CANVAS_WIDTH:  cfg_w_in = pwdata[CFW-1:0];
            default:                    cfg_h_in = pwdata[CFW-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff <= CFW'(256);
         cfg_h_ff <= CFW'(256);
      end else begin
         cfg_w_ff <= cfg_w_in;
         cfg_h_ff <= cfg_h_in;
      end
   end

   always_comb begin
      unique case (paddr[2])
         ffl_pkg::REG_CANVAS_WIDTH:  prdata = {{(32 - CFW){1'b0}}, cfg_w_ff};
         default:                    prdata = {{(32 - CFW){1'b0}}, cfg_h_ff};
      endcase
   end

   // zero acts as one, oversize clamps to the maximum
   always_comb begin
      if (cfg_w_ff == '0) begin
         eff_w = CDW'(1);
      end else if ({{(CDW - CFW){1'b0}}, cfg_w_ff} > CDW'(MAX_WIDTH)) begin
         eff_w = CDW'(MAX_WIDTH);
      end else begin
         eff_w = {{(CDW - CFW){1'b0}}, cfg_w_ff};
      end
      if (cfg_h_ff == '0) begin
         eff_h = CDW'(1);
      end else if ({{(CDW - CFW){1'b0}}, cfg_h_ff} > CDW'(MAX_HEIGHT)) begin
         eff_h = CDW'(MAX_HEIGHT);
      end else begin
         eff_h = {{(CDW - CFW){1'b0}}, cfg_h_ff};
      end
   end

   ffl_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_cmd      (req_cmd),
      .req_pos_x    (req_pos_x),
      .req_pos_y    (req_pos_y),
      .req_extent_a (req_extent_a),
      .req_extent_b (req_extent_b),
      .req_color    (req_color),
      .eff_w        (eff_w),
      .eff_h        (eff_h),
      .clr_done     (clr_done),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_span       (push_span)
   );

   ffl_span_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_span (push_span),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_span  (pop_span)
   );

   ffl_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .eff_w              (eff_w),
      .clr_done           (clr_done),
      .q_valid            (q_valid),
      .q_span             (pop_span),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_read_value     (rsp_read_value),
      .rsp_pixels_written (rsp_pixels_written)
   );

endmodule
